@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(lbl, cond, msg) \
   `ASSERT_AT(lbl, !(cond), msg)

`endif

@@ sv/tprrt_pkg.sv @@
package tprrt_pkg;

   localparam int ROOM_SLOTS   = 64;
   localparam int BUDGET_SLOTS = 64;
   localparam int MAX_PACKET   = 1504;

   localparam int ROOM_AW    = $clog2(ROOM_SLOTS);
   localparam int BUDGET_AW  = $clog2(BUDGET_SLOTS);
   localparam int SCAN_SLOTS = (ROOM_SLOTS > BUDGET_SLOTS) ? ROOM_SLOTS : BUDGET_SLOTS;
   localparam int SCAN_W     = $clog2(SCAN_SLOTS + 1);
   localparam int CNT_W      = $clog2(ROOM_SLOTS + 1);

   localparam int MS_PER_SEC = 1000;
   localparam int MIN_PACKET = 5;
   localparam int HDR_BYTES  = 4;
   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      V_FORWARD   = 3'd0,
      V_NOPARTNER = 3'd1,
      V_SHORT     = 3'd2,
      V_CAP       = 3'd3,
      V_RATE      = 3'd4,
      V_BUSY      = 3'd5,
      V_TICK      = 3'd6,
      V_OFF       = 3'd7
   } verdict_type;

   typedef enum logic [2:0] {
      CSR_ENABLE    = 3'd0,
      CSR_MAX_ROOMS = 3'd1,
      CSR_STALE     = 3'd2,
      CSR_TIMEOUT   = 3'd3,
      CSR_WINDOW    = 3'd4,
      CSR_MAX_NEW   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
      logic [31:0] seen;
   } peer_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] last_active;
      peer_type    p1;
      peer_type    p0;
   } room_row_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] wstart;
      logic [7:0]  count;
   } budget_row_type;

   typedef struct packed {
      logic busy;
      logic me;
   } peer_dec_type;

   typedef struct packed {
      logic [6:0]  rooms_evicted;
      logic [10:0] payload_len;
      logic [15:0] dest_port;
      logic [31:0] dest_addr;
      verdict_type verdict;
   } result_type;

endpackage

@@ sv/tprrt_ram.sv @@
module tprrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/tprrt_peer_sel.sv @@
module tprrt_peer_sel import tprrt_pkg::*; (
   input  peer_type     p0,
   input  peer_type     p1,
   input  logic         live0,
   input  logic         live1,
   input  logic [31:0]  addr,
   input  logic [15:0]  port,
   input  logic [31:0]  now,
   input  logic [31:0]  stale,
   output peer_dec_type dec
);

   logic        m0, m1, c0, c1;
   logic [31:0] oldest;
   logic [31:0] age;

   assign m0     = live0 && p0.addr == addr && p0.port == port;
   assign m1     = live1 && p1.addr == addr && p1.port == port;
   // oldest candidate, lower slot wins a tie, never-seen marker excluded
   assign c0     = p0.seen != TIME_MAX;
   assign c1     = p1.seen < (c0 ? p0.seen : TIME_MAX);
   assign oldest = c1 ? p1.seen : p0.seen;
   assign age    = now - oldest;

   always_comb begin
      dec = '0;
      if (m0) begin
         dec.me = 1'b0;
      end else if (m1) begin
         dec.me = 1'b1;
      end else if (!live0) begin
         dec.me = 1'b0;
      end else if (!live1) begin
         dec.me = 1'b1;
      end else begin
         dec.me   = c1;
         dec.busy = !(c0 || c1) || (age <= stale);
      end
   end

endmodule

@@ sv/two_peer_room_relay_table.sv @@
// a packet scans the room table and, for a new room, the budget table as well;
// short or disabled requests skip scans; a second-boundary tick sweeps both tables
// throughput: one request at a time, set by the single read port of each table
// memory that is scanned one entry per cycle; ticks subtract 1000 ms per step
// reset: synchronous, clears time, valid bits and registers; no memory clearing pass
`include "assert_macros.svh"

module two_peer_room_relay_table import tprrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // room_id, sender_addr, sender_port, packet_len, elapsed_ms, zero fill
   input  logic [111:0] req_tdata,
   // action
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // dest_addr, dest_port, payload_len, rooms_evicted, zero fill
   output logic [71:0]  rsp_tdata,
   // verdict
   output logic [2:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_TMOD, S_SWEEP, S_RSCAN, S_RDEC, S_BSCAN, S_BDEC, S_PEER, S_POST
   } state_type;

   state_type state_ff;

   // configuration
   logic        enabled_ff;
   logic [6:0]  max_rooms_ff;
   logic [31:0] stale_ff, timeout_ff, window_ff;
   logic [7:0]  max_new_ff;

   // time
   logic [31:0] now_ff;
   logic [16:0] rem_ff;
   logic        cross_ff;

   // valid bits
   logic [ROOM_SLOTS-1:0]   room_live_ff;
   logic [2*ROOM_SLOTS-1:0] peer_live_ff;
   logic [BUDGET_SLOTS-1:0] budget_live_ff;

   // request being worked on
   logic [31:0] room_id_ff, addr_ff;
   logic [15:0] port_ff;
   logic [10:0] len_ff;

   // scan bookkeeping
   logic [SCAN_W-1:0]    idx_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     ev_ff;
   logic                 found_ff, free_found_ff, bfound_ff, bfree_ff;
   logic [ROOM_AW-1:0]   room_ff, free_ff;
   logic [BUDGET_AW-1:0] bslot_ff, bfree_slot_ff;
   room_row_type         row_ff;
   budget_row_type       brow_ff;

   result_type res_ff, rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_load;

   // memories
   room_row_type   room_rdata, room_wdata;
   budget_row_type bud_rdata, bud_wdata;
   logic           room_we, bud_we;
   logic [BUDGET_AW-1:0] bud_waddr;

   tprrt_ram #(.WIDTH($bits(room_row_type)), .DEPTH(ROOM_SLOTS)) u_room_ram (
      .clock (clock),
      .we    (room_we),
      .waddr (room_ff),
      .wdata (room_wdata),
      .raddr (idx_ff[ROOM_AW-1:0]),
      .rdata (room_rdata)
   );

   tprrt_ram #(.WIDTH($bits(budget_row_type)), .DEPTH(BUDGET_SLOTS)) u_budget_ram (
      .clock (clock),
      .we    (bud_we),
      .waddr (bud_waddr),
      .wdata (bud_wdata),
      .raddr (idx_ff[BUDGET_AW-1:0]),
      .rdata (bud_rdata)
   );

   // request fields
   logic [31:0] in_room, in_addr;
   logic [15:0] in_port, in_elapsed;
   logic [10:0] in_len, len_clamped;

   assign in_room    = req_tdata[31:0];
   assign in_addr    = req_tdata[63:32];
   assign in_port    = req_tdata[79:64];
   assign in_len     = req_tdata[90:80];
   assign in_elapsed = req_tdata[106:91];
   // receive buffer truncation
   assign len_clamped = (14'(in_len) > 14'(MAX_PACKET)) ? 11'(MAX_PACKET) : in_len;

   // tick arithmetic: the whole second changes on a carry past 1000 or on wrap
   logic [32:0] tick_sum;
   logic [16:0] rem_sum, tick_rem;
   logic        tick_cross;

   assign tick_sum   = {1'b0, now_ff} + 33'(in_elapsed);
   assign rem_sum    = rem_ff + 17'(in_elapsed);
   assign tick_rem   = tick_sum[32] ? 17'(tick_sum[15:0]) : rem_sum;
   assign tick_cross = tick_sum[32] || (rem_sum >= 17'(MS_PER_SEC));

   // scan position: data on the read port belongs to the entry before idx
   logic [SCAN_W-1:0]    scan_j;
   logic                 scan_proc;
   logic [ROOM_AW-1:0]   room_j;
   logic [BUDGET_AW-1:0] bud_j;
   logic                 room_ok, bud_ok;

   assign scan_j    = idx_ff - SCAN_W'(1);
   assign scan_proc = idx_ff != '0;
   assign room_j    = scan_j[ROOM_AW-1:0];
   assign bud_j     = scan_j[BUDGET_AW-1:0];
   assign room_ok   = scan_proc && scan_j < SCAN_W'(ROOM_SLOTS);
   assign bud_ok    = scan_proc && scan_j < SCAN_W'(BUDGET_SLOTS);

   // sweep decisions
   logic             sw_room, sw_bud;
   logic [CNT_W-1:0] ev_next;

   assign sw_room = room_ok && room_live_ff[room_j]
                    && (now_ff - room_rdata.last_active) > timeout_ff;
   assign sw_bud  = bud_ok && budget_live_ff[bud_j]
                    && (now_ff - bud_rdata.wstart) > window_ff;
   assign ev_next = ev_ff + CNT_W'(sw_room);

   // room cap
   logic [7:0] cap;
   assign cap = ({1'b0, max_rooms_ff} > 8'(ROOM_SLOTS)) ? 8'(ROOM_SLOTS)
                                                          : {1'b0, max_rooms_ff};

   // budget charge
   logic [31:0] ws0, ws1;
   logic [7:0]  c0, c1, c2;
   logic        expired, allow;

   assign bud_waddr = bfound_ff ? bslot_ff : bfree_slot_ff;
   assign ws0       = bfound_ff ? brow_ff.wstart : '0;
   assign c0        = bfound_ff ? brow_ff.count : '0;
   assign expired   = (now_ff - ws0) >= window_ff;
   assign ws1       = expired ? now_ff : ws0;
   assign c1        = expired ? 8'd0 : c0;
   assign allow     = c1 < max_new_ff;
   assign c2        = allow ? c1 + 8'd1 : c1;
   assign bud_wdata = '{addr: addr_ff, wstart: ws1, count: c2};
   assign bud_we    = (state_ff == S_BDEC) && (bfound_ff || bfree_ff);

   // peer slot choice
   logic         p0live, p1live, other_live;
   peer_dec_type dec;
   peer_type     other, me_new;

   assign p0live = peer_live_ff[{room_ff, 1'b0}];
   assign p1live = peer_live_ff[{room_ff, 1'b1}];

   tprrt_peer_sel u_peer_sel (
      .p0    (row_ff.p0),
      .p1    (row_ff.p1),
      .live0 (p0live),
      .live1 (p1live),
      .addr  (addr_ff),
      .port  (port_ff),
      .now   (now_ff),
      .stale (stale_ff),
      .dec   (dec)
   );

   assign other_live = dec.me ? p0live : p1live;
   assign other      = dec.me ? row_ff.p0 : row_ff.p1;
   assign me_new     = '{addr: addr_ff, port: port_ff, seen: now_ff};
   assign room_we    = state_ff == S_PEER;

   // result moves to the output register once that register is free
   assign rsp_load = (state_ff == S_POST) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      room_wdata             = row_ff;
      room_wdata.key         = room_id_ff;
      room_wdata.last_active = now_ff;
      if (!dec.busy) begin
         if (dec.me) begin
            room_wdata.p1 = me_new;
         end else begin
            room_wdata.p0 = me_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         enabled_ff     <= 1'b0;
         max_rooms_ff   <= 7'd64;
         stale_ff       <= 32'd10000;
         timeout_ff     <= 32'd60000;
         window_ff      <= 32'd1000;
         max_new_ff     <= 8'd4;
         now_ff         <= '0;
         rem_ff         <= '0;
         room_live_ff   <= '0;
         peer_live_ff   <= '0;
         budget_live_ff <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  room_id_ff <= in_room;
                  addr_ff    <= in_addr;
                  port_ff    <= in_port;
                  len_ff     <= len_clamped;
                  if (!enabled_ff) begin
                     res_ff   <= '{verdict: V_OFF, default: '0};
                     state_ff <= S_POST;
                  end else if (req_tuser[0]) begin
                     res_ff   <= '0;
                     now_ff   <= tick_sum[31:0];
                     rem_ff   <= tick_rem;
                     cross_ff <= tick_cross;
                     state_ff <= S_TMOD;
                  end else if (len_clamped < 11'(MIN_PACKET)) begin
                     res_ff   <= '{verdict: V_SHORT, default: '0};
                     state_ff <= S_POST;
                  end else begin
                     res_ff        <= '0;
                     idx_ff        <= '0;
                     cnt_ff        <= '0;
                     found_ff      <= 1'b0;
                     free_found_ff <= 1'b0;
                     state_ff      <= S_RSCAN;
                  end
               end
            end

            // bring the millisecond remainder back below one second
            S_TMOD: begin
               if (rem_ff >= 17'(MS_PER_SEC)) begin
                  rem_ff <= rem_ff - 17'(MS_PER_SEC);
               end else if (cross_ff) begin
                  idx_ff   <= '0;
                  ev_ff    <= '0;
                  state_ff <= S_SWEEP;
               end else begin
                  res_ff.verdict <= V_TICK;
                  state_ff       <= S_POST;
               end
            end

            S_SWEEP: begin
               idx_ff <= idx_ff + SCAN_W'(1);
               ev_ff  <= ev_next;
               if (sw_room) begin
                  room_live_ff[room_j]          <= 1'b0;
                  peer_live_ff[{room_j, 1'b0}]  <= 1'b0;
                  peer_live_ff[{room_j, 1'b1}]  <= 1'b0;
               end
               if (sw_bud) begin
                  budget_live_ff[bud_j] <= 1'b0;
               end
               if (idx_ff == SCAN_W'(SCAN_SLOTS)) begin
                  res_ff.verdict       <= V_TICK;
                  res_ff.rooms_evicted <= 7'(ev_next);
                  state_ff             <= S_POST;
               end
            end

            S_RSCAN: begin
               idx_ff <= idx_ff + SCAN_W'(1);
               if (room_ok) begin
                  if (room_live_ff[room_j]) begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                     if (room_rdata.key == room_id_ff && !found_ff) begin
                        found_ff <= 1'b1;
                        room_ff  <= room_j;
                        row_ff   <= room_rdata;
                     end
                  end else if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_ff       <= room_j;
                  end
               end
               if (idx_ff == SCAN_W'(ROOM_SLOTS)) begin
                  state_ff <= S_RDEC;
               end
            end

            S_RDEC: begin
               if (found_ff) begin
                  state_ff <= S_PEER;
               end else if (8'(cnt_ff) >= cap || !free_found_ff) begin
                  res_ff.verdict <= V_CAP;
                  state_ff       <= S_POST;
               end else begin
                  idx_ff    <= '0;
                  bfound_ff <= 1'b0;
                  bfree_ff  <= 1'b0;
                  state_ff  <= S_BSCAN;
               end
            end

            S_BSCAN: begin
               idx_ff <= idx_ff + SCAN_W'(1);
               if (bud_ok) begin
                  if (budget_live_ff[bud_j]) begin
                     if (bud_rdata.addr == addr_ff && !bfound_ff) begin
                        bfound_ff <= 1'b1;
                        bslot_ff  <= bud_j;
                        brow_ff   <= bud_rdata;
                     end
                  end else if (!bfree_ff) begin
                     bfree_ff      <= 1'b1;
                     bfree_slot_ff <= bud_j;
                  end
               end
               if (idx_ff == SCAN_W'(BUDGET_SLOTS)) begin
                  state_ff <= S_BDEC;
               end
            end

            // the budget entry is written back even when the charge fails
            S_BDEC: begin
               if (!bfound_ff && !bfree_ff) begin
                  res_ff.verdict <= V_RATE;
                  state_ff       <= S_POST;
               end else begin
                  budget_live_ff[bud_waddr] <= 1'b1;
                  if (!allow) begin
                     res_ff.verdict <= V_RATE;
                     state_ff       <= S_POST;
                  end else begin
                     room_live_ff[free_ff]          <= 1'b1;
                     peer_live_ff[{free_ff, 1'b0}]  <= 1'b0;
                     peer_live_ff[{free_ff, 1'b1}]  <= 1'b0;
                     room_ff                        <= free_ff;
                     state_ff                       <= S_PEER;
                  end
               end
            end

            S_PEER: begin
               state_ff <= S_POST;
               if (dec.busy) begin
                  res_ff.verdict <= V_BUSY;
               end else begin
                  peer_live_ff[{room_ff, dec.me}] <= 1'b1;
                  if (other_live) begin
                     res_ff.verdict     <= V_FORWARD;
                     res_ff.dest_addr   <= other.addr;
                     res_ff.dest_port   <= other.port;
                     res_ff.payload_len <= len_ff - 11'(HDR_BYTES);
                  end else begin
                     res_ff.verdict <= V_NOPARTNER;
                  end
               end
            end

            // output register frees the next request from a stalled consumer
            S_POST: begin
               if (rsp_load) begin
                  rsp_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // configuration writes must arrive while idle, unchecked by the block; enable writes empty the tables
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE: begin
                  enabled_ff     <= csr_wdata[0];
                  room_live_ff   <= '0;
                  peer_live_ff   <= '0;
                  budget_live_ff <= '0;
               end
               CSR_MAX_ROOMS: max_rooms_ff <= csr_wdata[6:0];
               CSR_STALE:     stale_ff     <= csr_wdata;
               CSR_TIMEOUT:   timeout_ff   <= csr_wdata;
               CSR_WINDOW:    window_ff    <= csr_wdata;
               CSR_MAX_NEW:   max_new_ff   <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.verdict;
   assign rsp_tdata  = {6'b0, rsp_ff.rooms_evicted, rsp_ff.payload_len,
                        rsp_ff.dest_port, rsp_ff.dest_addr};

   // a live peer always belongs to a live room
   logic orphan_peer;
   always_comb begin
      orphan_peer = 1'b0;
      for (int i = 0; i < ROOM_SLOTS; i++) begin
         orphan_peer = orphan_peer
                       | ((peer_live_ff[2*i] | peer_live_ff[2*i+1]) & ~room_live_ff[i]);
      end
   end

   // every valid bit clear
   logic tables_empty;
   assign tables_empty = room_live_ff == '0 && peer_live_ff == '0 && budget_live_ff == '0;

   `ASSERT_NEVER(a_orphan_peer, orphan_peer, "peer live in a dead room")
   `ASSERT_AT(a_enable_clears, csr_we && csr_index == CSR_ENABLE |=> tables_empty, "tables kept")
   `ASSERT_AT(a_rsp_from_post, $rose(rsp_valid_ff) |-> $past(state_ff == S_POST), "result raised outside post")

endmodule
